// ===== rtl/lsnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked stack node pool package
// Payload types and operation and status codes shared by the stack design.
// ----------------------------------------------------------------------------
package lsnp_pkg;

    typedef enum logic [1:0] {
        MODE_PUSH    = 2'd0,
        MODE_POP     = 2'd1,
        MODE_REVERSE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] top_value;
        logic       is_empty;
        logic       is_full;
    } t_out_item;

endpackage

// ===== rtl/lsnp_ram.sv =====
// ----------------------------------------------------------------------------
// Linked stack node pool RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lsnp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/linked_stack_node_pool_unit.sv =====
// ----------------------------------------------------------------------------
// Linked stack node pool unit
// Byte stack kept as a linked list in a pool of nodes with a free list.
//
// The input channel carries one operation per transfer: push, pop or reverse.
// Each operation yields exactly one result transfer with the status, the top
// byte and the empty and full flags after the operation.
// Both channels use valid and stall. The block takes one operation at a time
// and stalls its input until the result has been loaded into the output
// register; a finished result may wait there while the next operation runs.
// A push reads the free node's link and then writes the new node; a pop reads
// the next link and, if the stack is not left empty, then the new top byte; a
// reverse turns each link as it walks the list, then reads the new top byte;
// errors and unused codes go straight to the result. The link memory's single
// read port, walked one node per cycle, sets the reverse time.
// After reset a clearing pass over all POOL_DEPTH nodes builds the free list
// in the link memory; the input is stalled during that pass.
// When the receiver stalls, the result holds in the output register and the
// next result waits in the sequencer until the register is free.
// ----------------------------------------------------------------------------
module linked_stack_node_pool_unit
    import lsnp_pkg::*;
#(
    parameter int POOL_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int IW = $clog2(POOL_DEPTH + 1);
    localparam logic [IW-1:0] NullPtr = IW'(POOL_DEPTH);
    localparam logic [IW-1:0] LastPtr = IW'(POOL_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PUSH,
        S_POP,
        S_REV,
        S_VAL,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [IW-1:0] r_clr;
    logic [IW-1:0] r_top;
    logic [IW-1:0] r_free;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_prev;
    logic [7:0]    r_val;
    logic [7:0]    r_top_value;
    logic [1:0]    r_status;

    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;
    logic [AW-1:0] link_raddr;
    logic [IW-1:0] link_rdata;
    logic          val_we;
    logic [AW-1:0] val_waddr;
    logic [7:0]    val_wdata;
    logic [AW-1:0] val_raddr;
    logic [7:0]    val_rdata;
    logic          out_load;

    lsnp_ram #(
        .DEPTH(POOL_DEPTH),
        .WIDTH(IW)
    ) u_links (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(link_raddr),
        .o_rdata(link_rdata)
    );

    lsnp_ram #(
        .DEPTH(POOL_DEPTH),
        .WIDTH(8)
    ) u_values (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!o_out_valid || !i_out_stall);

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_cur[AW-1:0];
        link_wdata = r_prev;
        link_raddr = r_top[AW-1:0];
        val_we     = 1'b0;
        val_waddr  = r_free[AW-1:0];
        val_wdata  = r_val;
        val_raddr  = r_cur[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                link_we    = 1'b1;
                link_waddr = r_clr[AW-1:0];
                link_wdata = (r_clr == '0) ? NullPtr : r_clr - 1'b1;
            end
            S_IDLE: begin
                if (i_in.mode == MODE_PUSH) begin
                    link_raddr = r_free[AW-1:0];
                end
            end
            S_PUSH: begin
                link_we    = 1'b1;
                link_waddr = r_free[AW-1:0];
                link_wdata = r_top;
                val_we     = 1'b1;
            end
            S_POP: begin
                link_we    = 1'b1;
                link_waddr = r_top[AW-1:0];
                link_wdata = r_free;
                val_raddr  = link_rdata[AW-1:0];
            end
            S_REV: begin
                link_we    = 1'b1;
                link_raddr = link_rdata[AW-1:0];
            end
            S_VAL, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= NullPtr;
            r_free      <= LastPtr;
            r_top_value <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                o_out_valid     <= 1'b1;
                o_out.status    <= r_status;
                o_out.top_value <= r_top_value;
                o_out.is_empty  <= (r_top == NullPtr);
                o_out.is_full   <= (r_free == NullPtr);
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LastPtr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val    <= i_in.push_value;
                        r_status <= STATUS_OK;
                        r_state  <= S_DONE;
                        unique case (i_in.mode)
                            MODE_PUSH: begin
                                if (r_free == NullPtr) begin
                                    r_status <= STATUS_OVERFLOW;
                                end else begin
                                    r_state <= S_PUSH;
                                end
                            end
                            MODE_POP: begin
                                if (r_top == NullPtr) begin
                                    r_status <= STATUS_EMPTY;
                                end else begin
                                    r_state <= S_POP;
                                end
                            end
                            MODE_REVERSE: begin
                                if (r_top == NullPtr) begin
                                    r_status <= STATUS_EMPTY;
                                end else begin
                                    r_cur   <= r_top;
                                    r_prev  <= NullPtr;
                                    r_state <= S_REV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_PUSH: begin
                    r_free      <= link_rdata;
                    r_top       <= r_free;
                    r_top_value <= r_val;
                    r_state     <= S_DONE;
                end
                S_POP: begin
                    r_top  <= link_rdata;
                    r_free <= r_top;
                    if (link_rdata == NullPtr) begin
                        r_top_value <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_VAL;
                    end
                end
                S_REV: begin
                    r_prev <= r_cur;
                    r_cur  <= link_rdata;
                    if (link_rdata == NullPtr) begin
                        r_top   <= r_cur;
                        r_state <= S_VAL;
                    end
                end
                S_VAL: begin
                    r_top_value <= val_rdata;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
